[hw/rtl/mlp_pkg.sv]
// Shared types, constants and helpers of the perceptron inference block.
`default_nettype none
package mlp_pkg;

  localparam int unsigned MAX_LAYERS = 4;
  localparam int unsigned MAX_WIDTH  = 16;
  localparam int unsigned DATA_BITS  = 16;
  localparam int unsigned FRAC_BITS  = DATA_BITS / 2;
  localparam int unsigned LAYER_BITS = $clog2(MAX_LAYERS);
  localparam int unsigned IDX_BITS   = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_BITS   = IDX_BITS + 1;
  localparam int unsigned LCNT_BITS  = LAYER_BITS + 1;
  localparam int unsigned PROD_BITS  = 2 * DATA_BITS;
  localparam int unsigned ACC_BITS   = PROD_BITS + IDX_BITS + 4;
  localparam int unsigned WADDR_BITS = LAYER_BITS + 2 * IDX_BITS;
  localparam int unsigned BADDR_BITS = LAYER_BITS + IDX_BITS;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_LAYER_COUNT  = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH  = 3'd1;
  localparam logic [2:0] REG_WIDTH_FIRST  = 3'd2;
  localparam logic [2:0] REG_WIDTH_SECOND = 3'd3;
  localparam logic [2:0] REG_WIDTH_THIRD  = 3'd4;
  localparam logic [2:0] REG_WIDTH_FOURTH = 3'd5;

  typedef enum logic [1:0] {
    CMD_WEIGHT  = 2'd0,
    CMD_BIAS    = 2'd1,
    CMD_FEATURE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  issue;
    logic                  first;
    logic                  src_b;
    logic [LAYER_BITS-1:0] layer;
    logic [IDX_BITS-1:0]   neuron;
    logic [IDX_BITS-1:0]   element;
    logic                  finish;
    logic                  relu;
    logic                  emit;
    logic                  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Zero reads as one, values above the limit saturate to it
  function automatic logic [CNT_BITS-1:0] clamp_width(logic [CNT_BITS-1:0] v);
    logic [CNT_BITS-1:0] r;
    r = v;
    if (v == '0) r = CNT_BITS'(1);
    else if (v > CNT_BITS'(MAX_WIDTH)) r = CNT_BITS'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [LCNT_BITS-1:0] clamp_layers(logic [LCNT_BITS-1:0] v);
    logic [LCNT_BITS-1:0] r;
    r = v;
    if (v == '0) r = LCNT_BITS'(1);
    else if (v > LCNT_BITS'(MAX_LAYERS)) r = LCNT_BITS'(MAX_LAYERS);
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mlp_ctrl.sv]
// Sequencer of the forward pass: neuron, element and layer counters.
`default_nettype none
module mlp_ctrl
  import mlp_pkg::*;
(
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  input  wire cmd_e                                 in_cmd_i,
  input  wire logic                                 in_last_i,
  input  wire logic [LCNT_BITS-1:0]                 layer_count_i,
  input  wire logic [CNT_BITS-1:0]                  input_width_i,
  input  wire logic [MAX_LAYERS-1:0][CNT_BITS-1:0]  layer_width_i,
  input  wire dp_status_t                           status_i,
  output logic                                      in_ready_o,
  output dp_cmd_t                                   cmd_o
);

  state_e                state_q, state_d;
  logic [LAYER_BITS-1:0] layer_q, layer_d;
  logic [IDX_BITS-1:0]   neuron_q, neuron_d;
  logic [IDX_BITS-1:0]   elem_q, elem_d;
  logic [CNT_BITS-1:0]   in_w_q, in_w_d;
  logic [CNT_BITS-1:0]   width_q, width_d;
  logic                  src_b_q, src_b_d;
  logic                  drain_q, drain_d;

  logic [LCNT_BITS-1:0]  layers;
  logic                  start, last_elem, last_neuron, last_layer;

  assign layers      = clamp_layers(layer_count_i);
  assign start       = in_valid_i && (in_cmd_i == CMD_FEATURE) && in_last_i;
  assign last_elem   = {1'b0, elem_q} == (in_w_q - CNT_BITS'(1));
  assign last_neuron = {1'b0, neuron_q} == (width_q - CNT_BITS'(1));
  assign last_layer  = {1'b0, layer_q} == (layers - LCNT_BITS'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_MAC;
      ST_MAC:    if (last_elem) state_d = ST_DRAIN;
      ST_DRAIN:  if (drain_q) state_d = ST_FINISH;
      ST_FINISH: begin
        if (!last_neuron) state_d = ST_MAC;
        else if (last_layer) state_d = ST_EMIT;
        else state_d = ST_MAC;
      end
      ST_EMIT:   if (status_i.out_free && last_neuron) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.issue       = (state_q == ST_MAC);
    cmd_o.first       = (elem_q == '0);
    cmd_o.src_b       = src_b_q;
    cmd_o.layer       = layer_q;
    cmd_o.neuron      = neuron_q;
    cmd_o.element     = elem_q;
    cmd_o.finish      = (state_q == ST_FINISH);
    cmd_o.relu        = !last_layer;
    cmd_o.emit        = (state_q == ST_EMIT) && status_i.out_free;
    cmd_o.emit_last   = last_neuron;
  end

  always_comb begin
    layer_d  = layer_q;
    neuron_d = neuron_q;
    elem_d   = elem_q;
    in_w_d   = in_w_q;
    width_d  = width_q;
    src_b_d  = src_b_q;
    drain_d  = drain_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          layer_d  = '0;
          neuron_d = '0;
          elem_d   = '0;
          in_w_d   = clamp_width(input_width_i);
          width_d  = clamp_width(layer_width_i[0]);
          src_b_d  = 1'b0;
        end
      end
      ST_MAC: begin
        elem_d  = elem_q + IDX_BITS'(1);
        drain_d = 1'b0;
      end
      ST_DRAIN: drain_d = 1'b1;
      ST_FINISH: begin
        elem_d = '0;
        if (!last_neuron) begin
          neuron_d = neuron_q + IDX_BITS'(1);
        end else begin
          neuron_d = '0;
          src_b_d  = !src_b_q;
          if (!last_layer) begin
            layer_d = layer_q + LAYER_BITS'(1);
            in_w_d  = width_q;
            width_d = clamp_width(layer_width_i[layer_q + LAYER_BITS'(1)]);
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free && !last_neuron) neuron_d = neuron_q + IDX_BITS'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      layer_q  <= '0;
      neuron_q <= '0;
      elem_q   <= '0;
      in_w_q   <= CNT_BITS'(1);
      width_q  <= CNT_BITS'(1);
      src_b_q  <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      layer_q  <= layer_d;
      neuron_q <= neuron_d;
      elem_q   <= elem_d;
      in_w_q   <= in_w_d;
      width_q  <= width_d;
      src_b_q  <= src_b_d;
      drain_q  <= drain_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mlp_dp.sv]
// Datapath: weight and bias memories, activation banks, MAC and output register.
`default_nettype none
module mlp_dp
  import mlp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_accept_i,
  input  wire cmd_e                  in_cmd_i,
  input  wire logic [LAYER_BITS-1:0] in_layer_i,
  input  wire logic [IDX_BITS-1:0]   in_neuron_i,
  input  wire logic [IDX_BITS-1:0]   in_element_i,
  input  wire logic [DATA_BITS-1:0]  in_value_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_status_t                 status_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [DATA_BITS-1:0]       out_value_o,
  output logic [IDX_BITS-1:0]        out_index_o,
  output logic                       out_last_o
);

  logic [DATA_BITS-1:0] wmem [MAX_LAYERS*MAX_WIDTH*MAX_WIDTH];
  logic [DATA_BITS-1:0] bmem [MAX_LAYERS*MAX_WIDTH];
  logic [DATA_BITS-1:0] act_a [MAX_WIDTH];
  logic [DATA_BITS-1:0] act_b [MAX_WIDTH];

  logic [DATA_BITS-1:0] w_rd_q, a_rd_q, b_rd_q;
  logic                 v1_q, f1_q, v2_q, f2_q;
  logic [PROD_BITS-1:0] prod_q;
  logic [ACC_BITS-1:0]  acc_q;
  logic                 out_valid_q;
  logic [DATA_BITS-1:0] out_value_q;
  logic [IDX_BITS-1:0]  out_index_q;
  logic                 out_last_q;

  logic [ACC_BITS-1:0]  sum;
  logic [ACC_BITS-FRAC_BITS-1:0] shifted;
  logic [DATA_BITS-1:0] sat, result;
  logic                 fits;

  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_cmd_i == CMD_WEIGHT) begin
      wmem[{in_layer_i, in_neuron_i, in_element_i}] <= in_value_i;
    end
    w_rd_q <= wmem[{cmd_i.layer, cmd_i.neuron, cmd_i.element}];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_cmd_i == CMD_BIAS) begin
      bmem[{in_layer_i, in_neuron_i}] <= in_value_i;
    end
    b_rd_q <= bmem[{cmd_i.layer, cmd_i.neuron}];
  end

  // Features land in bank A; each layer writes the bank it does not read
  always_ff @(posedge clk_i) begin
    if (in_accept_i && in_cmd_i == CMD_FEATURE) begin
      act_a[in_element_i] <= in_value_i;
    end else if (cmd_i.finish && cmd_i.src_b) begin
      act_a[cmd_i.neuron] <= result;
    end
    if (cmd_i.finish && !cmd_i.src_b) begin
      act_b[cmd_i.neuron] <= result;
    end
    a_rd_q <= cmd_i.src_b ? act_b[cmd_i.element] : act_a[cmd_i.element];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      f1_q <= 1'b0;
      v2_q <= 1'b0;
      f2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      f1_q <= cmd_i.first;
      v2_q <= v1_q;
      f2_q <= f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'($signed(w_rd_q)) * PROD_BITS'($signed(a_rd_q));
    if (v2_q) begin
      if (f2_q) acc_q <= ACC_BITS'($signed(prod_q));
      else acc_q <= acc_q + ACC_BITS'($signed(prod_q));
    end
  end

  // Add bias, floor to Q8.8, saturate, optional ReLU
  always_comb begin
    sum     = acc_q + {{(ACC_BITS-DATA_BITS-FRAC_BITS){b_rd_q[DATA_BITS-1]}},
                       b_rd_q, {FRAC_BITS{1'b0}}};
    shifted = sum[ACC_BITS-1:FRAC_BITS];
    fits    = (shifted[ACC_BITS-FRAC_BITS-1:DATA_BITS-1] == '0) ||
              (shifted[ACC_BITS-FRAC_BITS-1:DATA_BITS-1] == '1);
    if (fits) sat = shifted[DATA_BITS-1:0];
    else if (shifted[ACC_BITS-FRAC_BITS-1]) sat = {1'b1, {(DATA_BITS-1){1'b0}}};
    else sat = {1'b0, {(DATA_BITS-1){1'b1}}};
    result = (cmd_i.relu && sat[DATA_BITS-1]) ? '0 : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= cmd_i.src_b ? act_b[cmd_i.neuron] : act_a[cmd_i.neuron];
      out_index_q <= cmd_i.neuron;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_value_o       = out_value_q;
  assign out_index_o       = out_index_q;
  assign out_last_o        = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/mlp_relu_inference.sv]
// Fixed-point MLP inference block with ReLU hidden layers (top level).
// Sequence: per neuron the MAC, DRAIN and FINISH states run in turn, layer by layer;
//   results are emitted after the last layer, one per cycle while the receiver is ready.
// Throughput: one load transaction per cycle; input held off from the last feature
//   until the last result of the run sits in the output register.
// Reset: registers return to one layer and widths of 16; stores stay undefined.
`default_nettype none
module mlp_relu_inference
  import mlp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // layer_sel[1:0], neuron_sel[5:2], element_sel[9:6], value[25:10], zero fill
  input  wire logic [31:0] s_tdata,
  // command[1:0]
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_value[15:0], out_index[19:16], zero fill
  output logic [23:0]      m_tdata,
  output logic             m_tlast,
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [LCNT_BITS-1:0]                layer_count_q;
  logic [CNT_BITS-1:0]                 input_width_q;
  logic [MAX_LAYERS-1:0][CNT_BITS-1:0] layer_width_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       in_accept;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic [DATA_BITS-1:0] out_value;
  logic [IDX_BITS-1:0]  out_index;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Write the registers only while no run is in flight; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= LCNT_BITS'(1);
      input_width_q <= CNT_BITS'(MAX_WIDTH);
      layer_width_q <= {MAX_LAYERS{CNT_BITS'(MAX_WIDTH)}};
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LAYER_COUNT:  layer_count_q    <= pwdata[LCNT_BITS-1:0];
        REG_INPUT_WIDTH:  input_width_q    <= pwdata[CNT_BITS-1:0];
        REG_WIDTH_FIRST:  layer_width_q[0] <= pwdata[CNT_BITS-1:0];
        REG_WIDTH_SECOND: layer_width_q[1] <= pwdata[CNT_BITS-1:0];
        REG_WIDTH_THIRD:  layer_width_q[2] <= pwdata[CNT_BITS-1:0];
        REG_WIDTH_FOURTH: layer_width_q[3] <= pwdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_LAYER_COUNT:  prdata = 32'(layer_count_q);
      REG_INPUT_WIDTH:  prdata = 32'(input_width_q);
      REG_WIDTH_FIRST:  prdata = 32'(layer_width_q[0]);
      REG_WIDTH_SECOND: prdata = 32'(layer_width_q[1]);
      REG_WIDTH_THIRD:  prdata = 32'(layer_width_q[2]);
      REG_WIDTH_FOURTH: prdata = 32'(layer_width_q[3]);
      default:          prdata = '0;
    endcase
  end

  assign in_accept = s_tvalid && s_tready;

  mlp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid),
    .in_cmd_i      (cmd_e'(s_tuser)),
    .in_last_i     (s_tlast),
    .layer_count_i (layer_count_q),
    .input_width_i (input_width_q),
    .layer_width_i (layer_width_q),
    .status_i      (dp_status),
    .in_ready_o    (s_tready),
    .cmd_o         (dp_cmd)
  );

  mlp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .in_cmd_i     (cmd_e'(s_tuser)),
    .in_layer_i   (s_tdata[1:0]),
    .in_neuron_i  (s_tdata[5:2]),
    .in_element_i (s_tdata[9:6]),
    .in_value_i   (s_tdata[25:10]),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .out_ready_i  (m_tready),
    .out_valid_o  (m_tvalid),
    .out_value_o  (out_value),
    .out_index_o  (out_index),
    .out_last_o   (m_tlast)
  );

  assign m_tdata = {4'b0000, out_index, out_value};

endmodule
`default_nettype wire

[tb/sv/mlp_checker.sv]
// Scoreboard of the perceptron inference block: predicts results from observed traffic.
`timescale 1ns / 100ps
module mlp_checker
  import mlp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               err_count,
  output int               pending
);

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  index;
    logic        last;
  } neuron_out_t;

  logic signed [15:0] weights [MAX_LAYERS][MAX_WIDTH][MAX_WIDTH];
  logic signed [15:0] biases  [MAX_LAYERS][MAX_WIDTH];
  logic signed [15:0] act     [2][MAX_WIDTH];
  logic [4:0]         regs    [6];
  neuron_out_t        outputs_due [$];

  function automatic int unsigned clamp_to(logic [4:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Walk every layer with the shared ping-pong vectors, queue the last layer
  task automatic forward_pass();
    int unsigned layers, in_w, width;
    int          src;
    longint      acc;
    longint      q;
    neuron_out_t r;
    layers = clamp_to(regs[REG_LAYER_COUNT], MAX_LAYERS);
    in_w   = clamp_to(regs[REG_INPUT_WIDTH], MAX_WIDTH);
    width  = 1;
    src    = 0;
    for (int unsigned l = 0; l < layers; l++) begin
      width = clamp_to(regs[REG_WIDTH_FIRST + l], MAX_WIDTH);
      for (int unsigned n = 0; n < width; n++) begin
        acc = 0;
        for (int unsigned e = 0; e < in_w; e++)
          acc += longint'(weights[l][n][e]) * longint'(act[src][e]);
        acc += longint'(biases[l][n]) * 256;
        q = acc >>> FRAC_BITS;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        if (l + 1 < layers && q < 0) q = 0;
        act[1-src][n] = q[15:0];
      end
      in_w = width;
      src  = 1 - src;
    end
    for (int unsigned n = 0; n < width; n++) begin
      r.value = act[src][n];
      r.index = n[3:0];
      r.last  = (n + 1 == width);
      outputs_due.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    neuron_out_t want;
    if (!rst_ni) begin
      regs[0] = 5'd1;
      for (int i = 1; i < 6; i++) regs[i] = 5'd16;
      outputs_due.delete();
      err_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:2] == REG_LAYER_COUNT) regs[0] = {2'b00, pwdata[2:0]};
        else if (paddr[4:2] < 6) regs[paddr[4:2]] = pwdata[4:0];
      end
      if (s_tvalid && s_tready) begin
        case (cmd_e'(s_tuser))
          CMD_WEIGHT:  weights[s_tdata[1:0]][s_tdata[5:2]][s_tdata[9:6]] = s_tdata[25:10];
          CMD_BIAS:    biases[s_tdata[1:0]][s_tdata[5:2]] = s_tdata[25:10];
          CMD_FEATURE: begin
            act[0][s_tdata[9:6]] = s_tdata[25:10];
            if (s_tlast) forward_pass();
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (outputs_due.size() == 0) begin
          err_count++;
          $display("%t: unexpected result value %h index %0d last %b",
                   $time, m_tdata[15:0], m_tdata[19:16], m_tlast);
        end else begin
          want = outputs_due.pop_front();
          if (m_tdata[15:0] !== want.value) begin
            err_count++;
            $display("%t: value expected %h actual %h", $time, want.value, m_tdata[15:0]);
          end
          if (m_tdata[19:16] !== want.index) begin
            err_count++;
            $display("%t: index expected %0d actual %0d", $time, want.index,
                     m_tdata[19:16]);
          end
          if (m_tlast !== want.last) begin
            err_count++;
            $display("%t: last expected %b actual %b", $time, want.last, m_tlast);
          end
        end
      end
    end
    pending = outputs_due.size();
  end

endmodule

[tb/sv/tb.sv]
// Top of the perceptron inference testbench: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 100ps
module tb;
  import mlp_pkg::*;

  localparam int DRAIN_CYCLES = 1300;  // longest run: 4 layers of 16 neurons with 16 inputs, plus results
  localparam int HOLD_CYCLES  = 3000;
  localparam int STALL_LIMIT  = 20000;
  localparam int FILL_WIDTH   = 4;     // neurons and elements per layer that get loaded

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int quiet_cycles = 0;
  bit gaps_on;     // allow random gaps on both sides
  bit hold_req;    // ask the receiver for one long hold-off
  bit hold_done;

  mlp_relu_inference uut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mlp_checker checker_i (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .err_count(errors), .pending(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(99) < 8);
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind completes
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly modest Q8.8 values so sums do not always saturate; sometimes any pattern
  function automatic logic [15:0] pick_value();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(1200)) - 600);
  endfunction

  // Offer one transaction at the falling edge and hold it until accepted
  task automatic send(cmd_e cmd, logic [1:0] lay, logic [3:0] neu, logic [3:0] ele,
                      logic [15:0] val, logic last);
    while (gaps_on && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tlast  <= last;
    s_tdata  <= {6'b0, val, ele, neu, lay};
    #1;
    while (!s_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    s_tvalid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {idx, 2'b00};
    pwdata   <= data;
    @(negedge clk_i);
    penable  <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the sender until every result is in, then let trailing loads settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic setup(logic [31:0] layers, logic [31:0] in_w, logic [31:0] w1,
                       logic [31:0] w2, logic [31:0] w3, logic [31:0] w4);
    drain();
    reg_write(REG_LAYER_COUNT, layers);
    reg_write(REG_INPUT_WIDTH, in_w);
    reg_write(REG_WIDTH_FIRST, w1);
    reg_write(REG_WIDTH_SECOND, w2);
    reg_write(REG_WIDTH_THIRD, w3);
    reg_write(REG_WIDTH_FOURTH, w4);
  endtask

  task automatic random_item();
    int          pick;
    logic [15:0] val;
    pick = $urandom_range(99);
    val  = pick_value();
    if (pick < 38)
      send(CMD_WEIGHT, 2'($urandom), 4'($urandom), 4'($urandom), val, 1'($urandom));
    else if (pick < 52)
      send(CMD_BIAS, 2'($urandom), 4'($urandom), 4'($urandom), val, 1'($urandom));
    else if (pick < 95)
      send(CMD_FEATURE, 2'($urandom), 4'($urandom), 4'($urandom), val,
           $urandom_range(3) == 0);
    else
      send(CMD_UNUSED, 2'($urandom), 4'($urandom), 4'($urandom), val, 1'($urandom));
  endtask

  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gaps_on  = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every run below stays within four neurons and four inputs per layer
    setup(4, FILL_WIDTH, FILL_WIDTH, FILL_WIDTH, FILL_WIDTH, FILL_WIDTH);

    // Load each weight, bias and feature that such runs read, so none is unwritten
    for (int l = 0; l < MAX_LAYERS; l++)
      for (int n = 0; n < FILL_WIDTH; n++) begin
        for (int e = 0; e < FILL_WIDTH; e++)
          send(CMD_WEIGHT, l[1:0], n[3:0], e[3:0], pick_value(), 1'b0);
        send(CMD_BIAS, l[1:0], n[3:0], 4'($urandom), pick_value(), 1'b0);
      end
    for (int e = 0; e < FILL_WIDTH; e++)
      send(CMD_FEATURE, 2'd0, 4'd0, e[3:0], pick_value(), 1'b0);

    // Directed: extremes, ignored last flags, unused command, stale run
    send(CMD_FEATURE, 2'd3, 4'd15, 4'd0, 16'h7fff, 1'b0);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd3, 16'h8000, 1'b1);
    send(CMD_WEIGHT, 2'd0, 4'd0, 4'd0, 16'h8000, 1'b1);
    send(CMD_WEIGHT, 2'd3, 4'd3, 4'd3, 16'h7fff, 1'b0);
    send(CMD_BIAS, 2'd3, 4'd3, 4'd15, 16'h7fff, 1'b1);
    send(CMD_BIAS, 2'd0, 4'd0, 4'd0, 16'h8000, 1'b0);
    send(CMD_UNUSED, 2'd3, 4'd15, 4'd15, 16'hffff, 1'b1);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd5, 16'h0000, 1'b1);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd2, 16'h0100, 1'b1);

    // Deepest network with a one-feature input and a narrow middle
    setup(4, 1, 4, 1, 4, 4);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd0, 16'h7fff, 1'b1);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd0, 16'h8000, 1'b1);

    // Zero counts read as one
    setup(0, 0, 0, 31, 31, 31);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd0, 16'h0180, 1'b1);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd3, 16'hff00, 1'b1);

    // Oversized layer count saturates to the maximum
    setup(7, 3, 2, 4, 1, 3);
    send(CMD_FEATURE, 2'd0, 4'd0, 4'd7, 16'h0040, 1'b1);

    // Random phases: small networks, first without gaps, then with gaps and pressure
    for (int ph = 0; ph < 4; ph++) begin
      setup($urandom_range(1, 4), $urandom_range(1, FILL_WIDTH),
            $urandom_range(1, FILL_WIDTH), $urandom_range(1, FILL_WIDTH),
            $urandom_range(1, FILL_WIDTH), $urandom_range(1, FILL_WIDTH));
      gaps_on  = (ph != 0);
      hold_req = (ph == 2);
      for (int i = 0; i < 6; i++) random_item();
      // Keep offering runs back to back so the block backs up during the hold-off
      if (ph == 2)
        for (int i = 0; i < 4; i++)
          send(CMD_FEATURE, 2'd0, 4'd0, 4'($urandom), pick_value(), 1'b1);
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
